[rtl/segment_tree_range_sum_core_assert.svh]
// assertion macros shared by the segment tree rtl
`ifndef SEGMENT_TREE_RANGE_SUM_CORE_ASSERT_SVH
`define SEGMENT_TREE_RANGE_SUM_CORE_ASSERT_SVH

// checked on every rising edge of i_clk, masked while i_rst_n is low
`define STST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every rising edge of i_clk, reset included
`define STST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/stst_pkg.sv]
// shared constants, types and helpers of the segment tree range sum core
`default_nettype none

package stst_pkg;

    localparam int TREE_DEPTH   = 11;
    localparam int NODE_BITS    = TREE_DEPTH;
    localparam int LEAF_BITS    = TREE_DEPTH - 1;
    localparam int NODE_COUNT   = 1 << TREE_DEPTH;
    localparam int LVL_W        = $clog2(TREE_DEPTH);
    localparam int SUM_W        = 64;
    localparam int LEAF_FIELD_W = 10;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [NODE_BITS-1:0] t_node;
    typedef logic [SUM_W-1:0]     t_sum;

    typedef struct packed {
        logic  we;
        t_node waddr;
        t_sum  wdata;
        t_node raddr;
    } t_mem_req;

    typedef struct packed {
        logic valid;
        t_sum sum;
    } t_result;

    // heap index of a leaf offset, offset wraps within the leaf level
    function automatic t_node leaf_node(input logic [LEAF_FIELD_W-1:0] offset);
        logic [31:0] ext;
        ext = 32'(offset);
        return {1'b1, ext[LEAF_BITS-1:0]};
    endfunction

endpackage

`default_nettype wire

[rtl/stst_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module stst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/stst_engine.sv]
// sequencer that walks the tree for updates, queries and the clearing pass
`default_nettype none

module stst_engine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_opcode,
    input  wire logic [stst_pkg::LEAF_FIELD_W-1:0]   i_first_leaf,
    input  wire logic [stst_pkg::LEAF_FIELD_W-1:0]   i_last_leaf,
    input  wire stst_pkg::t_sum                      i_new_value,
    output logic                                     o_busy,
    output stst_pkg::t_mem_req                       o_mem,
    input  wire stst_pkg::t_sum                      i_rd_data,
    output stst_pkg::t_result                        o_res,
    input  wire logic                                i_res_ready
);

    `include "segment_tree_range_sum_core_assert.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_ULEAF = 4'd2;
    localparam logic [3:0] S_URD   = 4'd3;
    localparam logic [3:0] S_UWR   = 4'd4;
    localparam logic [3:0] S_QHI   = 4'd5;
    localparam logic [3:0] S_QLVL  = 4'd6;
    localparam logic [3:0] S_QEND  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [stst_pkg::LVL_W-1:0] LAST_LVL = stst_pkg::LVL_W'(stst_pkg::TREE_DEPTH - 1);

    logic [3:0]                  r_state, n_state;
    stst_pkg::t_node             r_lo, n_lo;
    stst_pkg::t_node             r_hi, n_hi;
    stst_pkg::t_node             r_node, n_node;
    stst_pkg::t_node             r_clr_addr, n_clr_addr;
    logic [stst_pkg::LVL_W-1:0]  r_level, n_level;
    logic                        r_side, n_side;
    logic                        r_acc_en, n_acc_en;
    stst_pkg::t_sum              r_value, n_value;
    stst_pkg::t_sum              r_diff, n_diff;
    stst_pkg::t_sum              r_acc, n_acc;

    stst_pkg::t_node             in_first_node;
    stst_pkg::t_node             in_last_node;
    logic                        span;

    assign in_first_node = stst_pkg::leaf_node(i_first_leaf);
    assign in_last_node  = stst_pkg::leaf_node(i_last_leaf);

    // path nodes more than one apart
    assign span = {1'b0, r_hi} > ({1'b0, r_lo} + (stst_pkg::NODE_BITS+1)'(1));

    always_comb begin
        n_state    = r_state;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_node     = r_node;
        n_clr_addr = r_clr_addr;
        n_level    = r_level;
        n_side     = r_side;
        n_value    = r_value;
        n_diff     = r_diff;
        n_acc      = r_acc;
        n_acc_en   = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_node;
        o_mem.wdata = r_value;
        o_mem.raddr = r_node;
        o_res.valid = 1'b0;
        o_res.sum   = r_acc;

        if (r_acc_en) begin
            n_acc = r_acc + i_rd_data;
        end

        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr_addr;
                o_mem.wdata = '0;
                n_clr_addr  = r_clr_addr + stst_pkg::NODE_BITS'(1);
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_mem.raddr = in_first_node;
                    if (i_opcode == stst_pkg::OP_UPDATE) begin
                        n_node  = in_first_node;
                        n_value = i_new_value;
                        n_state = S_ULEAF;
                    end else if (in_first_node > in_last_node) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_lo     = in_first_node;
                        n_hi     = in_last_node;
                        n_acc    = '0;
                        n_acc_en = 1'b1;
                        n_state  = S_QHI;
                    end
                end
            end
            S_ULEAF: begin
                // leaf takes the new value, ancestors take the difference
                n_diff      = r_value - i_rd_data;
                o_mem.we    = 1'b1;
                o_mem.waddr = r_node;
                o_mem.wdata = r_value;
                n_node      = r_node >> 1;
                n_level     = stst_pkg::LVL_W'(1);
                n_state     = S_URD;
            end
            S_URD: begin
                o_mem.raddr = r_node;
                n_state     = S_UWR;
            end
            S_UWR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_node;
                o_mem.wdata = i_rd_data + r_diff;
                if (r_level == LAST_LVL) begin
                    n_state = S_IDLE;
                end else begin
                    n_node  = r_node >> 1;
                    n_level = r_level + stst_pkg::LVL_W'(1);
                    n_state = S_URD;
                end
            end
            S_QHI: begin
                o_mem.raddr = r_hi;
                n_acc_en    = r_hi > r_lo;
                n_level     = '0;
                n_side      = 1'b0;
                n_state     = S_QLVL;
            end
            S_QLVL: begin
                if (!r_side) begin
                    o_mem.raddr = r_lo ^ stst_pkg::NODE_BITS'(1);
                    n_acc_en    = span && !r_lo[0];
                    n_side      = 1'b1;
                end else begin
                    o_mem.raddr = r_hi ^ stst_pkg::NODE_BITS'(1);
                    n_acc_en    = span && r_hi[0];
                    n_side      = 1'b0;
                    n_lo        = r_lo >> 1;
                    n_hi        = r_hi >> 1;
                    if (r_level == LAST_LVL) begin
                        n_state = S_QEND;
                    end else begin
                        n_level = r_level + stst_pkg::LVL_W'(1);
                    end
                end
            end
            S_QEND: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_level    <= '0;
            r_side     <= 1'b0;
            r_acc_en   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_level    <= n_level;
            r_side     <= n_side;
            r_acc_en   <= n_acc_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_node  <= n_node;
        r_value <= n_value;
        r_diff  <= n_diff;
        r_acc   <= n_acc;
    end

    assign o_busy = r_state != S_IDLE;

    `STST_ASSERT(a_clear_writes_zero, (r_state == S_CLEAR) |-> (o_mem.we && o_mem.wdata == '0), "clearing pass must write zero")
    `STST_ASSERT(a_query_no_write, (r_state == S_QHI || r_state == S_QLVL || r_state == S_QEND || r_state == S_DONE) |-> !o_mem.we, "query must not write the tree")
    `STST_ASSERT(a_update_walk, (r_state == S_UWR) |=> (r_state == S_URD || r_state == S_IDLE), "update walk left its read-modify-write loop")

endmodule

`default_nettype wire

[rtl/segment_tree_range_sum_core.sv]
// top level of the segment tree range sum core
`default_nettype none

// Point update / range sum over 2^(TREE_DEPTH-1) leaves of 64-bit values, kept as a
// heap-layout segment tree in one node ram (one write port, one registered read port).
// After reset the core runs a clearing pass that writes zero to all NODE_COUNT node
// addresses (2048 at the default depth); o_in_stall stays high for that time. An update
// (opcode 0) reads the leaf, writes the new value and then does one read-modify-write
// per ancestor, a read state and a write state each through the single read port, with
// no result. A query (opcode 1) issues one node read per cycle - both end leaves, then up
// to two siblings per level - and accumulates them as the data returns; the sum then goes
// to the output register. An empty range (first beyond last) puts 0 in the output register
// without walking the tree. Leaf offsets wrap within the leaf level, sums wrap modulo 2^64.
// One item is in work at a time; a finished sum waits in the output register while the
// next item is already taken.
module segment_tree_range_sum_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_opcode,
    input  wire logic [stst_pkg::LEAF_FIELD_W-1:0]  i_first_leaf,
    input  wire logic [stst_pkg::LEAF_FIELD_W-1:0]  i_last_leaf,
    input  wire logic [stst_pkg::SUM_W-1:0]         i_new_value,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [stst_pkg::SUM_W-1:0]         o_range_sum
);

    `include "segment_tree_range_sum_core_assert.svh"

    stst_pkg::t_mem_req mem;
    stst_pkg::t_sum     rd_data;
    stst_pkg::t_result  res;
    logic               res_ready;
    logic               busy;

    logic               r_out_valid;
    stst_pkg::t_sum     r_out_sum;

    // node storage
    stst_ram #(
        .WIDTH (stst_pkg::SUM_W),
        .DEPTH (stst_pkg::NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rd_data)
    );

    // tree walker
    stst_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_opcode     (i_opcode),
        .i_first_leaf (i_first_leaf),
        .i_last_leaf  (i_last_leaf),
        .i_new_value  (i_new_value),
        .o_busy       (busy),
        .o_mem        (mem),
        .i_rd_data    (rd_data),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    // walker only takes a transfer when idle
    assign o_in_stall = busy;

    // output register frees the walker as soon as the sum is handed over
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_sum <= res.sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_sum;

    `STST_ASSERT_ALWAYS(a_stall_after_reset, !i_rst_n |=> o_in_stall, "input must stall during the clearing pass")
    `STST_ASSERT(a_result_lands, (res.valid && res_ready) |=> (o_out_valid && o_range_sum == $past(res.sum)), "handed sum did not reach the output register")

endmodule

`default_nettype wire
